// ===== design/lmd_pkg.sv =====
package lmd_pkg;

   localparam int GRID_NODES_DEF = 1024;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DENS_W = 48;
   localparam int SUM_W  = 64;
   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_DEPOSIT = 2'd1,
      KIND_READ    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_ORIGIN  = 2'd0,
      CSR_INVSP   = 2'd1,
      CSR_NODES   = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MUL,
      ST_SPLIT,
      ST_WMUL,
      ST_SHARE,
      ST_VMUL,
      ST_RD,
      ST_ACC,
      ST_WR,
      ST_RREAD,
      ST_RWAIT,
      ST_DIV,
      ST_OUT
   } state_type;

   // One node's accumulators as stored in memory.
   typedef struct packed {
      logic [DENS_W-1:0] dens;
      logic [SUM_W-1:0]  vx;
      logic [SUM_W-1:0]  vy;
      logic [SUM_W-1:0]  vz;
   } node_type;

   // Divider handshake: the start it was given, and its busy and done status.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

   function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = a + b;
      if (!a[SUM_W-1] && !b[SUM_W-1] && s[SUM_W-1])
         return {1'b0, {(SUM_W-1){1'b1}}};
      if (a[SUM_W-1] && b[SUM_W-1] && !s[SUM_W-1])
         return {1'b1, {(SUM_W-1){1'b0}}};
      return s;
   endfunction

endpackage

// ===== design/linear_moment_deposit_1d_top.sv =====
// Linear cloud-in-cell moment deposition on a 1D grid.
// Requests arrive on req_* (stream handshake). tuser carries the kind:
// clear, deposit or read. Only reads produce a response on rsp_*.
// The user must write registers on csr_* only while the block is idle;
// the block itself does not enforce it. All node sums live in one
// single-port-read, single-port-write memory with a registered read;
// the sequencer handles one request at a time. A deposit runs a position
// multiply, a weight split, then one read-modify-write pass through the
// memory per node: two passes, or one when the whole weight goes to one node.
// A read fetches the node from the memory, runs the three velocity sums in
// turn through the shared restoring divider, which produces one quotient
// bit per cycle, and loads the output register before raising rsp_tvalid.
// A node with zero density skips the divider.
// A clear sweeps the memory, one node per cycle, over all GRID_NODES nodes.
// After reset the same sweep runs before req_tready rises; csr writes
// are taken during it.
// A response stays in the output register until rsp_tready; a stalled
// receiver only holds the block in that state, nothing is lost.
module linear_moment_deposit_1d_top
   import lmd_pkg::*;
#(
   parameter int GRID_NODES = GRID_NODES_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int AW = $clog2(GRID_NODES),
   localparam int NW = $clog2(GRID_NODES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata from bit 0: position[31:0], stat_weight, vel_x, vel_y, vel_z,
   // node_index[9:0], then 6 zero bits
   input  logic [175:0]  req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata from bit 0: node_density[47:0], mean_vel_x, mean_vel_y,
   // mean_vel_z, was_normalized, then 7 zero bits
   output logic [151:0]  rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data
);
   localparam logic [DENS_W-1:0] DENS_MAX = '1;

   logic signed [31:0] origin_ff;
   logic [31:0]        invsp_ff;
   logic [10:0]        nodes_ff;

   state_type state_ff, state_in;

   logic [AW:0]        sweep_ff, sweep_in;
   logic [31:0]        w_ff, wr_ff, share_ff;
   logic signed [31:0] vel_ff [3];
   logic signed [32:0] d_ff;
   logic [64:0]        p_ff;
   logic [AW-1:0]      node_ff, node_in, left_ff, last_ff;
   logic               second_ff, single_ff;
   logic [SUM_W-1:0]   prod_ff [3];
   node_type           acc_ff;
   logic [1:0]         comp_ff;
   logic [DENS_W-1:0]  rden_ff;
   logic [SUM_W-1:0]   rsum_ff [3];
   logic [WORD_W-1:0]  mean_ff [3];
   logic               norm_ff, oob_ff;
   logic [151:0]       rsp_ff;
   logic               rsp_valid_ff;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   node_type           ram_wdata, ram_rdata;
   logic               div_start;
   div_ctl_type        div_ctl;
   logic [WORD_W-1:0]  div_mean;
   logic [SUM_W-1:0]   div_sum;
   logic [NW-1:0]      n_clamp;

   kind_type           kind;
   logic [9:0]         req_node;
   logic               take;

   assign kind = kind_type'(req_tuser);
   assign req_node = req_tdata[169:160];
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign take = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      if (nodes_ff < 11'd1) n_clamp = NW'(1);
      else if (32'(nodes_ff) > 32'(GRID_NODES)) n_clamp = NW'(GRID_NODES);
      else n_clamp = NW'(nodes_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         invsp_ff <= 32'd65536;
         nodes_ff <= 11'd1024;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN: origin_ff <= csr_data;
            CSR_INVSP:  invsp_ff <= csr_data;
            CSR_NODES:  nodes_ff <= csr_data[10:0];
            CSR_UNUSED: ;
         endcase
      end
   end

   lmd_node_ram #(.GRID_NODES(GRID_NODES)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   lmd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .sum(div_sum),
      .den(rden_ff), .ctl(div_ctl), .mean(div_mean)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            unique case (kind)
               KIND_CLEAR:   state_in = ST_CLEAR;
               KIND_DEPOSIT: state_in = ST_MUL;
               KIND_READ:    state_in = ST_RREAD;
               KIND_NONE:    state_in = ST_IDLE;
            endcase
         end
         ST_CLEAR: if (sweep_ff[AW-1:0] == AW'(GRID_NODES - 1)) state_in = ST_IDLE;
         ST_MUL:   state_in = d_ff[32] || d_ff == '0 ? ST_WMUL : ST_SPLIT;
         ST_SPLIT: state_in = ST_WMUL;
         ST_WMUL:  state_in = ST_SHARE;
         ST_SHARE: state_in = ST_VMUL;
         ST_VMUL:  state_in = ST_RD;
         ST_RD:    state_in = ST_ACC;
         ST_ACC:   state_in = ST_WR;
         ST_WR:    state_in = (second_ff || single_ff) ? ST_IDLE : ST_SHARE;
         ST_RREAD: state_in = ST_RWAIT;
         ST_RWAIT: state_in = ST_DIV;
         ST_DIV:   if (div_ctl.done && (comp_ff == 2'd2 || !norm_ff)) state_in = ST_OUT;
                   else if (!norm_ff) state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Memory and divider controls.
   always_comb begin
      ram_we = 1'b0;
      ram_waddr = node_ff;
      ram_wdata = acc_ff;
      ram_raddr = node_ff;
      div_start = 1'b0;
      // A finishing division restarts the divider on the next component.
      if (div_ctl.done && comp_ff != 2'd2) div_sum = rsum_ff[comp_ff + 2'd1];
      else div_sum = rsum_ff[comp_ff];
      node_in = node_ff;
      sweep_in = sweep_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = sweep_ff[AW-1:0];
            ram_wdata = '0;
            sweep_in = sweep_ff + 1'b1;
         end
         ST_WR: ram_we = 1'b1;
         ST_DIV: div_start = norm_ff && ((comp_ff == 2'd0 && !div_ctl.busy
                                          && !div_ctl.done && sweep_ff == '0)
                                         || (div_ctl.done && comp_ff != 2'd2));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE || state_ff == ST_OUT) sweep_ff <= '0;
         else if (state_ff == ST_CLEAR) sweep_ff <= sweep_in;
         else if (div_start) sweep_ff <= {{AW{1'b0}}, 1'b1};
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: if (take) begin
            d_ff <= 33'(signed'(req_tdata[31:0])) - 33'(origin_ff);
            w_ff <= req_tdata[63:32];
            vel_ff[0] <= req_tdata[95:64];
            vel_ff[1] <= req_tdata[127:96];
            vel_ff[2] <= req_tdata[159:128];
            node_ff <= AW'(req_node);
            oob_ff <= 32'(req_node) >= 32'(GRID_NODES);
            second_ff <= 1'b0;
            last_ff <= AW'(n_clamp - 1'b1);
         end
         ST_MUL: begin
            p_ff <= {33'd0, d_ff[31:0]} * {33'd0, invsp_ff};
            node_ff <= '0;
            single_ff <= 1'b1;
            wr_ff <= '0;
         end
         ST_SPLIT: begin
            if (p_ff[64:2*FRAC_BITS] >= 65'(last_ff)) begin
               node_ff <= last_ff;
               single_ff <= 1'b1;
            end else begin
               left_ff <= AW'(p_ff[64:2*FRAC_BITS]);
               node_ff <= AW'(p_ff[64:2*FRAC_BITS]);
               single_ff <= 1'b0;
            end
         end
         ST_WMUL: if (!single_ff) begin
            wr_ff <= 32'(({32'd0, w_ff} * 64'(p_ff[2*FRAC_BITS-1:FRAC_BITS]))
                         >> FRAC_BITS);
         end
         ST_SHARE: begin
            share_ff <= second_ff ? wr_ff : (w_ff - wr_ff);
            if (second_ff) node_ff <= left_ff + 1'b1;
         end
         ST_VMUL: for (int i = 0; i < 3; i++)
            prod_ff[i] <= $signed({32'd0, share_ff}) * 64'(vel_ff[i]);
         ST_ACC: begin
            acc_ff.dens <= ({1'b0, ram_rdata.dens} + 49'(share_ff)) > 49'(DENS_MAX)
                           ? DENS_MAX : ram_rdata.dens + DENS_W'(share_ff);
            acc_ff.vx <= sat_add64(ram_rdata.vx, prod_ff[0]);
            acc_ff.vy <= sat_add64(ram_rdata.vy, prod_ff[1]);
            acc_ff.vz <= sat_add64(ram_rdata.vz, prod_ff[2]);
         end
         ST_WR: second_ff <= 1'b1;
         ST_RWAIT: begin
            rden_ff <= oob_ff ? '0 : ram_rdata.dens;
            rsum_ff[0] <= ram_rdata.vx;
            rsum_ff[1] <= ram_rdata.vy;
            rsum_ff[2] <= ram_rdata.vz;
            norm_ff <= !oob_ff && ram_rdata.dens != '0;
            comp_ff <= 2'd0;
            for (int i = 0; i < 3; i++) mean_ff[i] <= '0;
         end
         ST_DIV: if (div_ctl.done) begin
            mean_ff[comp_ff] <= div_mean;
            if (comp_ff != 2'd2) comp_ff <= comp_ff + 1'b1;
         end
         ST_OUT: rsp_ff <= {7'd0, norm_ff, mean_ff[2], mean_ff[1], mean_ff[0], rden_ff};
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_ff;
endmodule

// ===== design/lmd_node_ram.sv =====
module lmd_node_ram
   import lmd_pkg::*;
#(
   parameter int GRID_NODES = GRID_NODES_DEF,
   localparam int AW = $clog2(GRID_NODES)
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  node_type       wr_data,
   input  logic [AW-1:0]  rd_addr,
   output node_type       rd_data
);
   node_type mem [GRID_NODES];
   node_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== design/lmd_divider.sv =====
module lmd_divider
   import lmd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_W-1:0]    sum,
   input  logic [DENS_W-1:0]   den,
   output div_ctl_type         ctl,
   output logic [WORD_W-1:0]   mean
);
   // Restoring division, one quotient bit per cycle, on the sum magnitude.
   localparam int CW = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DENS_W:0]   rem_ff, rem_in;
   logic [DENS_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [SUM_W-1:0]  mag;
   logic [DENS_W:0]   trial;

   always_comb begin
      mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DENS_W-1:0], quo_ff[SUM_W-1]};
      if (start) begin
         quo_in = mag;
         rem_in = '0;
         den_in = den;
         neg_in = sum[SUM_W-1];
         cnt_in = CW'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (quo_ff > 64'h8000_0000) mean = 32'h8000_0000;
         else mean = WORD_W'(~quo_ff + 1'b1);
      end else begin
         if (quo_ff > 64'h7FFF_FFFF) mean = 32'h7FFF_FFFF;
         else mean = quo_ff[WORD_W-1:0];
      end
   end

   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
endmodule

// ===== design/lmd_checker.sv =====
module lmd_checker
   import lmd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [151:0] rsp_tdata
);
   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No request is taken while a response waits.
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted with pending response");

   // An unnormalized response carries zero velocities.
   a_zero_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[144] |-> rsp_tdata[143:48] == '0)
      else $error("raw response with nonzero velocity");

   // Normalized implies a positive density.
   a_norm_dens: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[144] |-> rsp_tdata[47:0] != '0)
      else $error("normalized with zero density");
endmodule

bind linear_moment_deposit_1d_top lmd_checker u_lmd_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import lmd_pkg::*;

   localparam int NODES      = 1024;
   localparam int PHASE_REQS = 255;
   localparam int SETTLE     = 1200;
   localparam int HOLD_LEN   = 3000;

   typedef struct packed {
      logic [47:0] dens;
      logic [31:0] mx;
      logic [31:0] my;
      logic [31:0] mz;
      logic        norm;
   } node_report_type;

   typedef struct {
      kind_type        kind;
      logic [31:0]     pos;
      logic [31:0]     w;
      logic [31:0]     vx;
      logic [31:0]     vy;
      logic [31:0]     vz;
      logic [9:0]      idx;
      bit              typed;
      node_report_type want;
   } stim_row_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [175:0]  req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [151:0]  rsp_tdata;
   logic          csr_valid;
   logic          csr_ready;
   logic [1:0]    csr_index;
   logic [31:0]   csr_data;

   linear_moment_deposit_1d_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predictor state
   longint      origin_q;
   logic [31:0] inv_spacing_q;
   logic [10:0] nodes_q;
   logic [47:0] dens_sum [NODES];
   longint      vx_sum [NODES];
   longint      vy_sum [NODES];
   longint      vz_sum [NODES];

   node_report_type pending_reports [$];
   int  mismatches;
   int  reports_seen;
   int  deposits_sent;
   int  reads_sent;
   int  clears_sent;
   bit  calm;
   bit  hold_request;
   bit  req_fire;
   bit  csr_fire;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Timeout with %0d reports still pending", pending_reports.size());
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      csr_fire <= csr_valid && csr_ready;
   end

   function automatic int used_nodes();
      if (nodes_q == 0) return 1;
      if (nodes_q > NODES) return NODES;
      return int'(nodes_q);
   endfunction

   function automatic longint add_clamped(longint a, longint b);
      longint s;
      s = a + b;
      if (a >= 0 && b >= 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'h8000_0000_0000_0000;
      return s;
   endfunction

   task automatic accumulate(int node, logic [31:0] share,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      logic [48:0] d;
      longint      sh;
      d  = {1'b0, dens_sum[node]} + share;
      sh = longint'({32'd0, share});
      dens_sum[node] = d[48] ? 48'hFFFF_FFFF_FFFF : d[47:0];
      vx_sum[node] = add_clamped(vx_sum[node], sh * longint'($signed(vx)));
      vy_sum[node] = add_clamped(vy_sum[node], sh * longint'($signed(vy)));
      vz_sum[node] = add_clamped(vz_sum[node], sh * longint'($signed(vz)));
   endtask

   task automatic deposit_particle(logic [31:0] pos, logic [31:0] w,
                                   logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      longint      rel_pos;
      logic [63:0] grid;
      logic [63:0] left;
      logic [63:0] right_share;
      int          last;
      last = used_nodes() - 1;
      rel_pos = longint'($signed(pos)) - origin_q;
      if (rel_pos <= 0) begin
         accumulate(0, w, vx, vy, vz);
         return;
      end
      grid = 64'(rel_pos) * {32'd0, inv_spacing_q};
      left = grid >> 32;
      if (left >= 64'(last)) begin
         accumulate(last, w, vx, vy, vz);
         return;
      end
      right_share = ({32'd0, w} * {48'd0, grid[31:16]}) >> 16;
      accumulate(int'(left), w - right_share[31:0], vx, vy, vz);
      accumulate(int'(left) + 1, right_share[31:0], vx, vy, vz);
   endtask

   function automatic logic [31:0] mean_velocity(longint sum, logic [47:0] den);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (sum < 0) ? 64'(-sum) : 64'(sum);
      q   = mag / {16'd0, den};
      if (sum < 0) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
   endfunction

   function automatic node_report_type node_report(logic [9:0] idx);
      node_report_type r;
      r = '0;
      r.dens = dens_sum[idx];
      if (r.dens != 0) begin
         r.mx   = mean_velocity(vx_sum[idx], r.dens);
         r.my   = mean_velocity(vy_sum[idx], r.dens);
         r.mz   = mean_velocity(vz_sum[idx], r.dens);
         r.norm = 1'b1;
      end
      return r;
   endfunction

   task automatic clear_sums();
      for (int i = 0; i < NODES; i++) begin
         dens_sum[i] = '0;
         vx_sum[i] = 0;
         vy_sum[i] = 0;
         vz_sum[i] = 0;
      end
   endtask

   // Drives one request and updates the predictor once it is accepted.
   task automatic send_request(stim_row_type row);
      req_tuser  = row.kind;
      req_tdata  = {6'd0, row.idx, row.vz, row.vy, row.vx, row.w, row.pos};
      req_tvalid = 1'b1;
      do @(negedge clock); while (!req_fire);
      case (row.kind)
         KIND_CLEAR: begin
            clear_sums();
            clears_sent++;
         end
         KIND_DEPOSIT: begin
            deposit_particle(row.pos, row.w, row.vx, row.vy, row.vz);
            deposits_sent++;
         end
         KIND_READ: begin
            pending_reports.push_back(row.typed ? row.want : node_report(row.idx));
            reads_sent++;
         end
         default: ;
      endcase
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] value);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(negedge clock); while (!csr_fire);
      csr_valid = 1'b0;
      case (idx)
         CSR_ORIGIN: origin_q = longint'($signed(value));
         CSR_INVSP:  inv_spacing_q = value;
         CSR_NODES:  nodes_q = value[10:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic stim_row_type random_row();
      stim_row_type r;
      int           pick;
      logic [63:0]  span;
      logic [63:0]  off;
      r = '{kind: KIND_DEPOSIT, pos: $urandom, w: $urandom, vx: $urandom, vy: $urandom,
            vz: $urandom, idx: 10'($urandom), typed: 1'b0, want: '0};
      pick = $urandom_range(0, 99);
      if (pick < 2) r.kind = KIND_CLEAR;
      else if (pick < 5) r.kind = KIND_NONE;
      else if (pick < 40) begin
         r.kind = KIND_READ;
         if ($urandom_range(0, 3) != 0) r.idx = 10'($urandom % used_nodes());
      end else begin
         // Most particles land inside the used grid, spread around the origin.
         if ($urandom_range(0, 4) != 0) begin
            span = (inv_spacing_q == 0) ? 64'hFFFF_FFFF
                 : (64'(used_nodes() + 1) << 32) / inv_spacing_q;
            if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
            off   = {$urandom, $urandom} % (span + 1);
            r.pos = 32'(origin_q) + off[31:0] - span[35:4];
         end
         if ($urandom_range(0, 2) != 0) r.w = $urandom_range(0, 32'h0004_0000);
         if ($urandom_range(0, 2) != 0) begin
            r.vx = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            r.vy = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            r.vz = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         end
      end
      return r;
   endfunction

   // Long receiver stall, counted here, and random ready bursts otherwise.
   initial begin
      int hold_count;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready = 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_LEN) begin
               @(negedge clock);
               hold_count++;
            end
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      node_report_type got;
      node_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[47:0], rsp_tdata[79:48], rsp_tdata[111:80],
                rsp_tdata[143:112], rsp_tdata[144]};
         reports_seen++;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %h", got);
         end else begin
            want = pending_reports.pop_front();
            if (got.dens !== want.dens || got.mx !== want.mx || got.my !== want.my
                || got.mz !== want.mz || got.norm !== want.norm
                || rsp_tdata[151:145] !== 7'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: dens %h/%h vx %h/%h vy %h/%h vz %h/%h norm %b/%b",
                           want.dens, got.dens, want.mx, got.mx, want.my, got.my,
                           want.mz, got.mz, want.norm, got.norm);
            end
         end
      end
   end

   initial begin
      stim_row_type directed [];
      logic [31:0] origin_set [6];
      logic [31:0] invsp_set [6];
      logic [31:0] nodes_set [6];
      int sent;
      int guard;
      stim_row_type r;

      origin_set = '{32'h0000_0000, 32'hFFF0_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     $urandom, 32'h0001_0000};
      invsp_set  = '{32'h0001_0000, 32'h0010_0000, 32'hFFFF_FFFF, 32'd1,
                     32'd0, 32'h0000_8000};
      nodes_set  = '{32'd64, 32'd2, 32'd1024, 32'd0, 32'd2047, 32'd300};

      directed = new[18];
      directed[0]  = '{KIND_READ, 0, 0, 0, 0, 0, 5, 1, '0};
      directed[1]  = '{KIND_READ, 0, 0, 0, 0, 0, 1023, 1, '0};
      directed[2]  = '{KIND_NONE, '1, '1, '1, '1, '1, '1, 0, '0};
      // Far below node zero: all of the weight stays at node 0.
      directed[3]  = '{KIND_DEPOSIT, 32'h8000_0000, 32'h0001_0000, 32'h0002_0000,
                       32'hFFFF_0000, 0, 0, 0, '0};
      directed[4]  = '{KIND_READ, 0, 0, 0, 0, 0, 0, 1,
                       '{48'h1_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0, 1'b1}};
      // Beyond the last node, twice, so the x and y velocity sums saturate.
      directed[5]  = '{KIND_DEPOSIT, 32'h7FFF_FFFF, '1, 32'h8000_0000, 32'h7FFF_FFFF,
                       '1, 0, 0, '0};
      directed[6]  = directed[5];
      directed[7]  = '{KIND_READ, 0, 0, 0, 0, 0, 1023, 0, '0};
      directed[8]  = '{KIND_DEPOSIT, 32'h0001_8000, '1, 32'h0123_4567, 32'hFEDC_BA98,
                       32'h0000_0001, 0, 0, '0};
      directed[9]  = '{KIND_READ, 0, 0, 0, 0, 0, 1, 0, '0};
      directed[10] = '{KIND_READ, 0, 0, 0, 0, 0, 2, 0, '0};
      directed[11] = '{KIND_DEPOSIT, 32'h0003_0000, 0, '1, '1, '1, 0, 0, '0};
      directed[12] = '{KIND_READ, 0, 0, 0, 0, 0, 3, 1, '0};
      // Exactly at the origin.
      directed[13] = '{KIND_DEPOSIT, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0000_8000, 0, 0, '0};
      directed[14] = '{KIND_READ, 0, 0, 0, 0, 0, 0, 0, '0};
      directed[15] = '{KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, '0};
      directed[16] = '{KIND_READ, 0, 0, 0, 0, 0, 0, 1, '0};
      directed[17] = '{KIND_READ, 0, 0, 0, 0, 0, 1023, 1, '0};

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_NONE;
      csr_valid = 1'b0;
      csr_index = CSR_ORIGIN;
      csr_data = '0;
      calm = 1'b0;
      hold_request = 1'b0;
      mismatches = 0;
      reports_seen = 0;
      deposits_sent = 0;
      reads_sent = 0;
      clears_sent = 0;
      origin_q = 0;
      inv_spacing_q = 32'h0001_0000;
      nodes_q = 11'd1024;
      clear_sums();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_request(directed[i]);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_register(CSR_ORIGIN, origin_set[ph]);
         write_register(CSR_INVSP, invsp_set[ph]);
         write_register(CSR_NODES, nodes_set[ph]);
         if (ph == 4) write_register(CSR_UNUSED, $urandom);
         calm = (ph == 5);
         if (ph == 1) hold_request = 1'b1;
         sent = 0;
         while (sent < PHASE_REQS) begin
            r = random_row();
            send_request(r);
            if (r.kind != KIND_NONE) sent++;
         end
      end

      req_tvalid = 1'b0;
      guard = 0;
      while (pending_reports.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE) @(negedge clock);
      if (pending_reports.size() != 0) mismatches += pending_reports.size();

      $display("Sent %0d deposits, %0d reads and %0d clears over six grid settings;",
               deposits_sent, reads_sent, clears_sent);
      $display("checked %0d node reports, %0d mismatches.", reports_seen, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
